// ===== rtl/ephemeris_store_and_best_match_defines.svh =====
// assertion helpers used by the checker file
`ifndef EPHEMERIS_STORE_AND_BEST_MATCH_DEFINES_SVH
`define EPHEMERIS_STORE_AND_BEST_MATCH_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet while arst_n is low
`define ESBM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet while arst_n is low
`define ESBM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/esbm_pkg.sv =====
`timescale 1ns / 1ps
package esbm_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int NUM_SYS     = 3;

	localparam int SYS_W   = 2;
	localparam int SAT_W   = 6;
	localparam int WEEK_W  = 13;
	localparam int REFS_W  = 20;
	localparam int QMS_W   = 30;
	localparam int SRC_W   = 8;
	localparam int STAT_W  = 2;
	localparam int OIDX_W  = 6;
	localparam int DIFF_W  = 13;

	localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
	localparam int RAM_DEPTH = NUM_SYS * TABLE_DEPTH;
	localparam int ADDR_W  = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
	localparam int REC_W   = SAT_W + WEEK_W + REFS_W + SRC_W;

	// floor(x / 1000) = (x * 274877907) >> 38 for any x below 2**32
	localparam int QSEC_W    = 21;
	localparam int RECIP_W   = 29;
	localparam int RECIP_SH  = 38;
	localparam int QPROD_W   = QMS_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;

	localparam int QWEEK_W = 15;
	localparam int SDIFF_W = 22;
	localparam int SUM_W   = 36;
	localparam logic signed [QWEEK_W-1:0] BDS_WEEK_OFS = 15'sd1356;
	localparam logic signed [20:0]        WEEK_SECS    = 21'sd604800;
	localparam logic signed [SUM_W-1:0]   SPAN_LIMIT   = 36'sd7200;

	localparam logic [SYS_W-1:0] SYS_GPS = 2'd0;
	localparam logic [SYS_W-1:0] SYS_BDS = 2'd1;
	localparam logic [SYS_W-1:0] SYS_GAL = 2'd2;

	localparam logic [STAT_W-1:0] STAT_STORED = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FOUND  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NONE   = 2'd3;

	localparam logic REQ_STORE = 1'b0;
	localparam logic REQ_FIND  = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_STORE,
		S_PREP,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} esbm_state_t;

	typedef struct packed {
		logic latch;
		logic store;
		logic prep;
		logic issue;
		logic finish;
		logic load_out;
	} esbm_cmd_t;

	typedef struct packed {
		logic is_find;
		logic count_zero;
		logic scan_last;
		logic pipe_empty;
		logic out_free;
	} esbm_sts_t;

	function automatic logic [OIDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] i);
		logic [IDX_W+OIDX_W-1:0] w;
		w = {{OIDX_W{1'b0}}, i};
		return w[OIDX_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] base_addr(input logic [SYS_W-1:0] s);
		logic [ADDR_W-1:0] b;
		case (s)
			SYS_BDS: b = ADDR_W'(TABLE_DEPTH);
			SYS_GAL: b = ADDR_W'(2 * TABLE_DEPTH);
			default: b = '0;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/esbm_ram.sv =====
`timescale 1ns / 1ps
module esbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/esbm_ctrl.sv =====
`timescale 1ns / 1ps
module esbm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  esbm_pkg::esbm_sts_t sts,
	output esbm_pkg::esbm_cmd_t cmd
);

	import esbm_pkg::*;

	esbm_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nx = sts.is_find ? S_PREP : S_STORE;
				end
			end
			S_STORE: state_nx = S_DONE;
			S_PREP: state_nx = sts.count_zero ? S_DRAIN : S_SCAN;
			S_SCAN: begin
				if (sts.scan_last) begin
					state_nx = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (sts.pipe_empty) begin
					state_nx = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall  = 1'b0;
				cmd.latch = in_valid;
			end
			S_STORE: cmd.store = 1'b1;
			S_PREP:  cmd.prep  = 1'b1;
			S_SCAN:  cmd.issue = 1'b1;
			S_DRAIN: cmd.finish = sts.pipe_empty;
			S_DONE:  cmd.load_out = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/esbm_dp.sv =====
`timescale 1ns / 1ps
module esbm_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  esbm_pkg::esbm_cmd_t               cmd,
	output esbm_pkg::esbm_sts_t               sts,
	input  logic                              req_type,
	input  logic [esbm_pkg::SYS_W-1:0]        system,
	input  logic [esbm_pkg::SAT_W-1:0]        sat_id,
	input  logic [esbm_pkg::WEEK_W-1:0]       week_number,
	input  logic [esbm_pkg::REFS_W-1:0]       ref_seconds,
	input  logic [esbm_pkg::QMS_W-1:0]        query_millis,
	input  logic [esbm_pkg::SRC_W-1:0]        source_code,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [esbm_pkg::STAT_W-1:0]       status,
	output logic [esbm_pkg::OIDX_W-1:0]       match_index,
	output logic [esbm_pkg::DIFF_W-1:0]       match_diff
);

	import esbm_pkg::*;

	// request holding registers
	logic [SYS_W-1:0]  sys_q;
	logic [SAT_W-1:0]  sat_q;
	logic [WEEK_W-1:0] week_q;
	logic [REFS_W-1:0] refs_q;
	logic [QMS_W-1:0]  qms_q;
	logic [SRC_W-1:0]  src_q;

	logic [CNT_W-1:0]  cnt_q [NUM_SYS];
	logic [CNT_W-1:0]  cur_cnt;
	logic              sys_ok;
	logic              store_ok;

	logic                      ram_we;
	logic [ADDR_W-1:0]         ram_waddr;
	logic [ADDR_W-1:0]         ram_raddr;
	logic [REC_W-1:0]          ram_wdata;
	logic [REC_W-1:0]          ram_rdata;

	logic [QPROD_W-1:0]        qprod_c;
	logic [QSEC_W-1:0]         qsec_q;
	logic signed [QWEEK_W-1:0] qweek_q;
	logic [IDX_W-1:0]          scan_idx_q;

	// scan pipeline
	logic                      v_s1, v_s2, v_s3;
	logic [IDX_W-1:0]          idx_s1, idx_s2, idx_s3;
	logic [SAT_W-1:0]          rd_sat;
	logic [WEEK_W-1:0]         rd_week;
	logic [REFS_W-1:0]         rd_refs;
	logic [SRC_W-1:0]          rd_src;
	logic signed [QWEEK_W-1:0] wdiff_c;
	logic signed [SUM_W-1:0]   prod_c;
	logic signed [SDIFF_W-1:0] sdiff_c;
	logic signed [SUM_W-1:0]   prod_s2;
	logic signed [SDIFF_W-1:0] sdiff_s2;
	logic                      sat_ok_s2, sat_ok_s3;
	logic                      src_eq_s2, src_eq_s3;
	logic signed [SUM_W-1:0]   sum_s3;
	logic signed [SUM_W-1:0]   abs_c;
	logic [DIFF_W-1:0]         diff_c;
	logic                      qual_c;
	logic                      take_c;

	logic                      have_q;
	logic [IDX_W-1:0]          best_idx_q;
	logic [DIFF_W-1:0]         best_diff_q;
	logic                      best_src_eq_q;

	logic [STAT_W-1:0]         res_stat_q;
	logic [OIDX_W-1:0]         res_idx_q;
	logic [DIFF_W-1:0]         res_diff_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			sys_q  <= system;
			sat_q  <= sat_id;
			week_q <= week_number;
			refs_q <= ref_seconds;
			qms_q  <= query_millis;
			src_q  <= source_code;
		end
	end

	assign sys_ok   = sys_q inside {SYS_GPS, SYS_BDS, SYS_GAL};
	assign cur_cnt  = sys_ok ? cnt_q[sys_q] : '0;
	assign store_ok = sys_ok && (cur_cnt < CNT_W'(TABLE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SYS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (cmd.store && store_ok) begin
			cnt_q[sys_q] <= CNT_W'(cur_cnt + CNT_W'(1));
		end
	end

	assign ram_we    = cmd.store && store_ok;
	assign ram_waddr = ADDR_W'(base_addr(sys_q) + ADDR_W'(cur_cnt[IDX_W-1:0]));
	assign ram_wdata = {sat_q, week_q, refs_q, src_q};
	assign ram_raddr = ADDR_W'(base_addr(sys_q) + ADDR_W'(scan_idx_q));

	esbm_ram #(
		.WIDTH(REC_W),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// query second by reciprocal multiply, query week shifted for bds
	assign qprod_c = QPROD_W'(qms_q) * QPROD_W'(RECIP_1000);

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			qsec_q  <= qprod_c[RECIP_SH +: QSEC_W];
			qweek_q <= $signed({2'b00, week_q}) - ((sys_q == SYS_BDS) ? BDS_WEEK_OFS : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			scan_idx_q <= '0;
		end else if (cmd.issue) begin
			scan_idx_q <= IDX_W'(scan_idx_q + IDX_W'(1));
		end
	end

	assign {rd_sat, rd_week, rd_refs, rd_src} = ram_rdata;

	assign wdiff_c = qweek_q - $signed({2'b00, rd_week});
	assign prod_c  = SUM_W'(wdiff_c) * SUM_W'(WEEK_SECS);
	assign sdiff_c = $signed({1'b0, qsec_q}) - $signed({2'b00, rd_refs});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1    <= scan_idx_q;
		idx_s2    <= idx_s1;
		prod_s2   <= prod_c;
		sdiff_s2  <= sdiff_c;
		sat_ok_s2 <= (rd_sat == sat_q);
		src_eq_s2 <= (rd_src == src_q);
		idx_s3    <= idx_s2;
		sum_s3    <= prod_s2 + SUM_W'(sdiff_s2);
		sat_ok_s3 <= sat_ok_s2;
		src_eq_s3 <= src_eq_s2;
	end

	assign abs_c  = sum_s3[SUM_W-1] ? -sum_s3 : sum_s3;
	assign diff_c = abs_c[DIFF_W-1:0];
	assign qual_c = v_s3 && sat_ok_s3 && (sum_s3 > -SPAN_LIMIT) && (sum_s3 < SPAN_LIMIT);
	assign take_c = qual_c && (!have_q || (!best_src_eq_q && src_eq_s3)
		|| (diff_c < best_diff_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (cmd.prep) begin
			have_q <= 1'b0;
		end else if (take_c) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_c) begin
			best_idx_q    <= idx_s3;
			best_diff_q   <= diff_c;
			best_src_eq_q <= src_eq_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			res_stat_q <= store_ok ? STAT_STORED : STAT_FULL;
			res_idx_q  <= store_ok ? to_out_idx(cur_cnt[IDX_W-1:0]) : '0;
			res_diff_q <= '0;
		end else if (cmd.finish) begin
			res_stat_q <= have_q ? STAT_FOUND : STAT_NONE;
			res_idx_q  <= have_q ? to_out_idx(best_idx_q) : '0;
			res_diff_q <= have_q ? best_diff_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status      <= res_stat_q;
			match_index <= res_idx_q;
			match_diff  <= res_diff_q;
		end
	end

	// request kind comes straight from the port: it is only looked at in idle
	always_comb begin
		sts.is_find    = (req_type == REQ_FIND);
		sts.count_zero = (cur_cnt == '0);
		sts.scan_last  = ((CNT_W'(scan_idx_q) + CNT_W'(1)) == cur_cnt);
		sts.pipe_empty = !v_s1 && !v_s2 && !v_s3;
		sts.out_free   = !out_valid || !out_stall;
	end

endmodule

// ===== rtl/ephemeris_store_and_best_match.sv =====
// channel | direction | handshake            | beat fields
// in      | input     | in_valid / in_stall  | req_type system sat_id week_number
//         |           |                      | ref_seconds query_millis source_code
// out     | output    | out_valid / out_stall| status match_index match_diff
//
// a store beat passes from the request latch through the store state and the status register to the result port
// a find beat reads one record per cycle from the single record ram port, then a
//   three-stage difference pipeline drains
// the next input beat is taken the cycle after the result register loads
// arst_n clears the state machine, the per-table counts and the valid flags;
//   record contents stay unknown until written
// out_stall holds the result register; the next input beat is still taken and
//   worked on, and only its hand-off to the result register waits
`timescale 1ns / 1ps
module ephemeris_store_and_best_match (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              req_type,
	input  logic [esbm_pkg::SYS_W-1:0]        system,
	input  logic [esbm_pkg::SAT_W-1:0]        sat_id,
	input  logic [esbm_pkg::WEEK_W-1:0]       week_number,
	input  logic [esbm_pkg::REFS_W-1:0]       ref_seconds,
	input  logic [esbm_pkg::QMS_W-1:0]        query_millis,
	input  logic [esbm_pkg::SRC_W-1:0]        source_code,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [esbm_pkg::STAT_W-1:0]       status,
	output logic [esbm_pkg::OIDX_W-1:0]       match_index,
	output logic [esbm_pkg::DIFF_W-1:0]       match_diff
);

	import esbm_pkg::*;

	// command and status between sequencer and datapath
	esbm_cmd_t cmd;
	esbm_sts_t sts;

	// sequencer: idle, store or prep/scan/drain for a find, then hand-off
	esbm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	// datapath: request latch, table counts, record ram, difference pipeline,
	// best-match tracking and the result register
	esbm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req_type),
		.system      (system),
		.sat_id      (sat_id),
		.week_number (week_number),
		.ref_seconds (ref_seconds),
		.query_millis(query_millis),
		.source_code (source_code),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.match_index (match_index),
		.match_diff  (match_diff)
	);

endmodule

// ===== rtl/esbm_checker.sv =====
`timescale 1ns / 1ps
`include "ephemeris_store_and_best_match_defines.svh"
module esbm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [esbm_pkg::STAT_W-1:0]       status,
	input logic [esbm_pkg::OIDX_W-1:0]       match_index,
	input logic [esbm_pkg::DIFF_W-1:0]       match_diff
);

	import esbm_pkg::*;

	// a result beat is held while stalled
	`ESBM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped")

	// one beat in flight: the cycle after an accept the input is stalled
	`ESBM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second beat taken")

	// only a found result carries a difference
	`ESBM_ASSERT_NOW(a_diff_zero, out_valid && status != STAT_FOUND, match_diff == '0,
		"difference on non-found result")

	// a found difference stays inside the window
	`ESBM_ASSERT_NOW(a_diff_window, out_valid && status == STAT_FOUND, match_diff < 13'd7200,
		"difference out of window")

	// refused stores and finds with no match report index zero
	`ESBM_ASSERT_NOW(a_idx_zero, out_valid && (status == STAT_FULL || status == STAT_NONE),
		match_index == '0, "index on refused or empty result")

endmodule

bind ephemeris_store_and_best_match esbm_checker u_esbm_checker (.*);
